FILE: hw/rtl/trsn_pkg.sv
// Package for the triangle radius select / face normal block.
// Holds widths, pipeline depths, CSR codes and the shared word structs.
// No dependencies.
package trsn_pkg;

   // Index check bound (triangle capacity)
   localparam int MAX_TRIANGLES = 65536;

   // Division and square-root pipeline depths of one normal lane
   localparam int DIV_STEPS   = 31;
   localparam int SQRT_STEPS  = 16;
   localparam int LANE_STAGES = DIV_STEPS + SQRT_STEPS;

   // CSR register codes
   typedef enum logic [1:0] {
      CSR_CENTER_X = 2'd0,
      CSR_CENTER_Z = 2'd1,
      CSR_RADIUS   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [23:0] center_x;
      logic signed [23:0] center_z;
      logic [22:0]        radius;
   } cfg_type;

   typedef struct packed {
      logic [15:0]        tri_index;
      logic signed [23:0] a_x;
      logic signed [23:0] a_y;
      logic signed [23:0] a_z;
      logic signed [23:0] b_x;
      logic signed [23:0] b_y;
      logic signed [23:0] b_z;
      logic signed [23:0] c_x;
      logic signed [23:0] c_y;
      logic signed [23:0] c_z;
      logic               placeable;
   } req_type;

   // Control that travels beside the numeric data
   typedef struct packed {
      logic        valid;
      logic [15:0] tri_index;
      logic        placeable;
      logic        degenerate;
      logic [2:0]  neg;
   } band_type;

   typedef struct packed {
      band_type         band;
      logic [2:0][47:0] r2;
      logic [49:0]      s_sum;
   } front_type;

   typedef struct packed {
      logic [15:0]        tri_index;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic               placeable;
      logic               degenerate;
   } rsp_type;

endpackage

FILE: hw/rtl/triangle_radius_select_normal_top.sv
// Top level of the triangle radius select / unit face normal block.
// Instantiates trsn_front, three trsn_lane and trsn_outbuf; uses trsn_pkg.
//
// Usage:
//   req_*  : one triangle word per handshake (index, three Q15.8 vertices, flag).
//   rsp_*  : one word per selected triangle: index, Q1.14 unit normal, flag,
//            degenerate. Triangles outside the radius or index range give none.
//   csr_*  : register writes (center x, center z, radius), always ready;
//            write only while no triangle is in flight.
// Pipeline: 56 register stages: 8 front stages (test, cross product,
//   reduction, sum of squares), 31 quotient-bit stages, 16 root-bit
//   stages, output register.
// Throughput: one triangle per cycle unless stalled; every stage works on its own word.
// Stall: the output register has one skid entry behind it. req_ready drops
//   and the whole pipeline holds only while that skid entry is full, so a word
//   waiting on rsp does not stop intake. Nothing is lost or repeated.
// Reset: synchronous; clears all valid bits and the configuration registers
//   to zero. Data registers are not reset.
module triangle_radius_select_normal_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [15:0]        req_tri_index,
   input  logic signed [23:0] req_a_x,
   input  logic signed [23:0] req_a_y,
   input  logic signed [23:0] req_a_z,
   input  logic signed [23:0] req_b_x,
   input  logic signed [23:0] req_b_y,
   input  logic signed [23:0] req_b_z,
   input  logic signed [23:0] req_c_x,
   input  logic signed [23:0] req_c_y,
   input  logic signed [23:0] req_c_z,
   input  logic               req_placeable_in,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [15:0]        rsp_tri_index_out,
   output logic signed [15:0] rsp_normal_x,
   output logic signed [15:0] rsp_normal_y,
   output logic signed [15:0] rsp_normal_z,
   output logic               rsp_placeable_out,
   output logic               rsp_degenerate,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [23:0]        csr_data
);

   localparam int LS = trsn_pkg::LANE_STAGES;

   trsn_pkg::cfg_type   cfg_ff;
   trsn_pkg::req_type   req_word;
   trsn_pkg::front_type front;
   trsn_pkg::band_type  band_ff [LS];
   trsn_pkg::rsp_type   res_word, rsp_word;
   logic [14:0]         mag [3];
   logic signed [15:0]  nrm [3];
   logic                en, skid_full;

   assign en        = !skid_full;
   assign req_ready = en;
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            trsn_pkg::CSR_CENTER_X: cfg_ff.center_x <= csr_data;
            trsn_pkg::CSR_CENTER_Z: cfg_ff.center_z <= csr_data;
            trsn_pkg::CSR_RADIUS:   cfg_ff.radius   <= csr_data[22:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      req_word.tri_index = req_tri_index;
      req_word.a_x       = req_a_x;
      req_word.a_y       = req_a_y;
      req_word.a_z       = req_a_z;
      req_word.b_x       = req_b_x;
      req_word.b_y       = req_b_y;
      req_word.b_z       = req_b_z;
      req_word.c_x       = req_c_x;
      req_word.c_y       = req_c_y;
      req_word.c_z       = req_c_z;
      req_word.placeable = req_placeable_in;
   end

   trsn_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .req_valid (req_valid),
      .req       (req_word),
      .cfg       (cfg_ff),
      .front     (front)
   );

   for (genvar i = 0; i < 3; i++) begin : g_lane
      trsn_lane u_lane (
         .clock (clock),
         .en    (en),
         .num   (front.r2[i]),
         .den   (front.s_sum),
         .mag   (mag[i])
      );
   end

   // control word travels beside the lanes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LS; k++) band_ff[k] <= '0;
      end else if (en) begin
         band_ff[0] <= front.band;
         for (int k = 1; k < LS; k++) band_ff[k] <= band_ff[k-1];
      end
   end

   // apply signs, zero normal for a degenerate triangle
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (band_ff[LS-1].degenerate) nrm[i] = '0;
         else if (band_ff[LS-1].neg[i]) nrm[i] = -16'(mag[i]);
         else nrm[i] = 16'(mag[i]);
      end
      res_word.tri_index  = band_ff[LS-1].tri_index;
      res_word.normal_x   = nrm[0];
      res_word.normal_y   = nrm[1];
      res_word.normal_z   = nrm[2];
      res_word.placeable  = band_ff[LS-1].placeable;
      res_word.degenerate = band_ff[LS-1].degenerate;
   end

   trsn_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (band_ff[LS-1].valid),
      .in_word   (res_word),
      .skid_full (skid_full),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_word  (rsp_word)
   );

   assign rsp_tri_index_out = rsp_word.tri_index;
   assign rsp_normal_x      = rsp_word.normal_x;
   assign rsp_normal_y      = rsp_word.normal_y;
   assign rsp_normal_z      = rsp_word.normal_z;
   assign rsp_placeable_out = rsp_word.placeable;
   assign rsp_degenerate    = rsp_word.degenerate;

`ifndef ASSERT_OFF
   // skid entry only fills behind a held output word
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_full |-> rsp_valid)
      else $error("skid entry full while output register empty");

   // degenerate triangle reports a zero normal
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |->
         (rsp_normal_x == 16'sd0 && rsp_normal_y == 16'sd0 && rsp_normal_z == 16'sd0))
      else $error("degenerate result with nonzero normal");

   // a real triangle always has a nonzero unit normal
   a_normal_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_degenerate) |->
         (rsp_normal_x != 16'sd0 || rsp_normal_y != 16'sd0 || rsp_normal_z != 16'sd0))
      else $error("nondegenerate result with zero normal");

   // stalled pipeline keeps its front-end control word
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      skid_full |=> $stable(band_ff[0]))
      else $error("pipeline moved while stalled");
`endif

endmodule

FILE: hw/rtl/trsn_front.sv
// Front pipeline: centroid radius test, edge cross product, magnitude reduction
// and sum of squares (eight register stages). Depends on trsn_pkg.
module trsn_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               req_valid,
   input  trsn_pkg::req_type  req,
   input  trsn_pkg::cfg_type  cfg,
   output trsn_pkg::front_type front
);

   trsn_pkg::band_type b1_ff, b2_ff, b3_ff, b4_ff, b5_ff, b6_ff, b7_ff, b8_ff;
   trsn_pkg::band_type b1_in, b4_in, b5_in;

   // stage 1: edges, centroid offsets, index check
   logic signed [24:0] e1_ff [3];
   logic signed [24:0] e2_ff [3];
   logic signed [24:0] e1_in [3];
   logic signed [24:0] e2_in [3];
   logic signed [26:0] dx1_ff, dz1_ff, dx1_in, dz1_in, cx3, cz3;
   logic               ok1_ff, ok1_in;

   always_comb begin
      e1_in[0] = 25'(req.b_x) - 25'(req.a_x);
      e1_in[1] = 25'(req.b_y) - 25'(req.a_y);
      e1_in[2] = 25'(req.b_z) - 25'(req.a_z);
      e2_in[0] = 25'(req.c_x) - 25'(req.a_x);
      e2_in[1] = 25'(req.c_y) - 25'(req.a_y);
      e2_in[2] = 25'(req.c_z) - 25'(req.a_z);
      cx3      = (27'(cfg.center_x) <<< 1) + 27'(cfg.center_x);
      cz3      = (27'(cfg.center_z) <<< 1) + 27'(cfg.center_z);
      dx1_in   = 27'(req.a_x) + 27'(req.b_x) + 27'(req.c_x) - cx3;
      dz1_in   = 27'(req.a_z) + 27'(req.b_z) + 27'(req.c_z) - cz3;
      ok1_in   = {9'd0, req.tri_index} < 25'(trsn_pkg::MAX_TRIANGLES);
      b1_in            = '0;
      b1_in.valid      = req_valid;
      b1_in.tri_index  = req.tri_index;
      b1_in.placeable  = req.placeable;
   end

   // stage 2: products
   logic signed [49:0] p2_ff [6];
   logic signed [49:0] p2_in [6];
   logic signed [53:0] dxsq2_ff, dzsq2_ff, dxsq2_in, dzsq2_in;
   logic [45:0]        rr2_ff, rr2_in;
   logic               ok2_ff;

   always_comb begin
      p2_in[0] = e1_ff[1] * e2_ff[2];
      p2_in[1] = e1_ff[2] * e2_ff[1];
      p2_in[2] = e1_ff[2] * e2_ff[0];
      p2_in[3] = e1_ff[0] * e2_ff[2];
      p2_in[4] = e1_ff[0] * e2_ff[1];
      p2_in[5] = e1_ff[1] * e2_ff[0];
      dxsq2_in = dx1_ff * dx1_ff;
      dzsq2_in = dz1_ff * dz1_ff;
      rr2_in   = cfg.radius * cfg.radius;
   end

   // stage 3: cross product, squared distance, limit
   logic signed [50:0] cr3_ff [3];
   logic signed [50:0] cr3_in [3];
   logic [53:0]        d2_3_ff, d2_3_in;
   logic [49:0]        lim3_ff, lim3_in;
   logic               ok3_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cr3_in[i] = 51'(p2_ff[2*i]) - 51'(p2_ff[2*i+1]);
      end
      d2_3_in = $unsigned(dxsq2_ff) + $unsigned(dzsq2_ff);
      lim3_in = (50'(rr2_ff) << 3) + 50'(rr2_ff);
   end

   // stage 4: select decision, magnitudes and signs
   logic [49:0] m4_ff [3];
   logic [49:0] m4_in [3];
   logic [49:0] orw4_ff, orw4_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         m4_in[i] = 50'((cr3_ff[i] < 0) ? -cr3_ff[i] : cr3_ff[i]);
      end
      orw4_in     = m4_in[0] | m4_in[1] | m4_in[2];
      b4_in       = b3_ff;
      b4_in.valid = b3_ff.valid & ok3_ff & (d2_3_ff <= 54'(lim3_ff));
      b4_in.neg   = {cr3_ff[2] < 0, cr3_ff[1] < 0, cr3_ff[0] < 0};
   end

   // stage 5: reduction shift count, zero detect
   logic [49:0] m5_ff [3];
   logic [4:0]  s5_ff, s5_in;

   always_comb begin
      s5_in = '0;
      for (int k = 0; k < 26; k++) begin
         if ((orw4_ff >> (24 + k)) != '0) s5_in = 5'(k + 1);
      end
      b5_in            = b4_ff;
      b5_in.degenerate = (orw4_ff == '0);
   end

   // stage 6: reduced magnitudes below 2^24
   logic [23:0] r6_ff [3];
   logic [23:0] r6_in [3];
   // stage 7: squares
   logic [47:0] q7_ff [3];
   logic [47:0] q7_in [3];
   // stage 8: sum of squares
   logic [47:0] q8_ff [3];
   logic [49:0] s8_ff, s8_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         r6_in[i] = 24'(m5_ff[i] >> s5_ff);
         q7_in[i] = r6_ff[i] * r6_ff[i];
      end
      s8_in = 50'(q7_ff[0]) + 50'(q7_ff[1]) + 50'(q7_ff[2]);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         b1_ff <= '0;
         b2_ff <= '0;
         b3_ff <= '0;
         b4_ff <= '0;
         b5_ff <= '0;
         b6_ff <= '0;
         b7_ff <= '0;
         b8_ff <= '0;
      end else if (en) begin
         b1_ff <= b1_in;
         b2_ff <= b1_ff;
         b3_ff <= b2_ff;
         b4_ff <= b4_in;
         b5_ff <= b5_in;
         b6_ff <= b5_ff;
         b7_ff <= b6_ff;
         b8_ff <= b7_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (en) begin
         e1_ff    <= e1_in;
         e2_ff    <= e2_in;
         dx1_ff   <= dx1_in;
         dz1_ff   <= dz1_in;
         ok1_ff   <= ok1_in;
         p2_ff    <= p2_in;
         dxsq2_ff <= dxsq2_in;
         dzsq2_ff <= dzsq2_in;
         rr2_ff   <= rr2_in;
         ok2_ff   <= ok1_ff;
         cr3_ff   <= cr3_in;
         d2_3_ff  <= d2_3_in;
         lim3_ff  <= lim3_in;
         ok3_ff   <= ok2_ff;
         m4_ff    <= m4_in;
         orw4_ff  <= orw4_in;
         m5_ff    <= m4_ff;
         s5_ff    <= s5_in;
         r6_ff    <= r6_in;
         q7_ff    <= q7_in;
         q8_ff    <= q7_ff;
         s8_ff    <= s8_in;
      end
   end

   always_comb begin
      front.band  = b8_ff;
      front.r2[0] = q8_ff[0];
      front.r2[1] = q8_ff[1];
      front.r2[2] = q8_ff[2];
      front.s_sum = s8_ff;
   end

endmodule

FILE: hw/rtl/trsn_lane.sv
// One normal component lane: q = floor((isqrt(floor(2^30*r2/S)) + 1) / 2).
// Restoring division, one quotient bit per stage, then one root bit per stage.
// Depends on trsn_pkg.
module trsn_lane (
   input  logic        clock,
   input  logic        en,
   input  logic [47:0] num,
   input  logic [49:0] den,
   output logic [14:0] mag
);

   localparam int DS = trsn_pkg::DIV_STEPS;
   localparam int RS = trsn_pkg::SQRT_STEPS;

   logic [50:0] rem_ff [DS-1];
   logic [49:0] den_ff [DS-1];
   logic [30:0] quo_ff [DS];
   logic [32:0] d_ff   [RS-1];
   logic [15:0] t_ff   [RS];

   // division: num <= den, so the top quotient bit takes no pre-shift
   for (genvar j = 0; j < DS; j++) begin : g_div
      logic [50:0] cand, rem_in;
      logic [49:0] den_src;
      logic [30:0] quo_src, quo_in;
      logic        ge;
      if (j == 0) begin : g_first
         assign cand    = 51'(num);
         assign den_src = den;
         assign quo_src = '0;
      end else begin : g_next
         assign cand    = rem_ff[j-1] << 1;
         assign den_src = den_ff[j-1];
         assign quo_src = quo_ff[j-1];
      end
      always_comb begin
         ge     = cand >= 51'(den_src);
         rem_in = ge ? cand - 51'(den_src) : cand;
         quo_in = {quo_src[29:0], ge};
      end
      always_ff @(posedge clock) begin
         if (en) quo_ff[j] <= quo_in;
      end
      if (j < DS - 1) begin : g_keep
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[j] <= rem_in;
               den_ff[j] <= den_src;
            end
         end
      end
   end

   // square root, remainder form: trial = T*2^(b+1) + 2^(2b)
   for (genvar i = 0; i < RS; i++) begin : g_sqrt
      localparam int B = RS - 1 - i;
      logic [32:0] d_src, trial, d_in;
      logic [15:0] t_src, t_in;
      logic        ge;
      if (i == 0) begin : g_first
         assign d_src = 33'(quo_ff[DS-1]);
         assign t_src = '0;
      end else begin : g_next
         assign d_src = d_ff[i-1];
         assign t_src = t_ff[i-1];
      end
      always_comb begin
         trial = (33'(t_src) << (B + 1)) | (33'(1) << (2 * B));
         ge    = d_src >= trial;
         d_in  = ge ? d_src - trial : d_src;
         t_in  = ge ? (t_src | (16'(1) << B)) : t_src;
      end
      always_ff @(posedge clock) begin
         if (en) t_ff[i] <= t_in;
      end
      if (i < RS - 1) begin : g_keep
         always_ff @(posedge clock) begin
            if (en) d_ff[i] <= d_in;
         end
      end
   end

   // largest q with 2q-1 <= root
   assign mag = 15'((17'(t_ff[RS-1]) + 17'd1) >> 1);

endmodule

FILE: hw/rtl/trsn_outbuf.sv
// Output register with one skid entry for the result channel.
// Upstream may push whenever skid_full is low. Depends on trsn_pkg.
module trsn_outbuf (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  trsn_pkg::rsp_type in_word,
   output logic              skid_full,
   output logic              out_valid,
   input  logic              out_ready,
   output trsn_pkg::rsp_type out_word
);

   logic              main_v_ff, skid_v_ff;
   trsn_pkg::rsp_type main_ff, skid_ff;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (main_v_ff && out_ready) begin
         if (skid_v_ff) begin
            skid_v_ff <= 1'b0;
         end else begin
            main_v_ff <= in_valid;
         end
      end else if (!main_v_ff) begin
         main_v_ff <= in_valid;
      end else if (in_valid && !skid_v_ff) begin
         skid_v_ff <= 1'b1;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (main_v_ff && out_ready) begin
         main_ff <= skid_v_ff ? skid_ff : in_word;
      end else if (!main_v_ff) begin
         main_ff <= in_word;
      end else if (!skid_v_ff) begin
         skid_ff <= in_word;
      end
   end

   assign skid_full = skid_v_ff;
   assign out_valid = main_v_ff;
   assign out_word  = main_ff;

endmodule

FILE: test/tb_triangle_radius_select_normal_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for triangle_radius_select_normal_top: radius test and unit normal.
// Depends on trsn_pkg and the top level only; predicts every word from its own model.
module tb_triangle_radius_select_normal_top;

   localparam int LIMIT_CYCLES = 500000;
   localparam int DRAIN_CYCLES = 70;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_ready;
   trsn_pkg::req_type req_word = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [15:0] rsp_tri_index_out;
   logic signed [15:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic rsp_placeable_out, rsp_degenerate;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [23:0] csr_data = '0;

   trsn_pkg::req_type pending_words[$];
   trsn_pkg::rsp_type expected_hits[$];
   trsn_pkg::cfg_type shadow_cfg = '0;
   int gap_left = 0;
   int stall_left = 0;
   int hold_left = 0;
   logic hold_request = 1'b0;
   bit quiet = 1'b0;
   int mismatches = 0;
   int cycles = 0;

   always #5 clock = ~clock;

   triangle_radius_select_normal_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_tri_index(req_word.tri_index),
      .req_a_x(req_word.a_x), .req_a_y(req_word.a_y), .req_a_z(req_word.a_z),
      .req_b_x(req_word.b_x), .req_b_y(req_word.b_y), .req_b_z(req_word.b_z),
      .req_c_x(req_word.c_x), .req_c_y(req_word.c_y), .req_c_z(req_word.c_z),
      .req_placeable_in(req_word.placeable),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_tri_index_out(rsp_tri_index_out),
      .rsp_normal_x(rsp_normal_x), .rsp_normal_y(rsp_normal_y),
      .rsp_normal_z(rsp_normal_z),
      .rsp_placeable_out(rsp_placeable_out), .rsp_degenerate(rsp_degenerate),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // append a word to the stimulus queue
   function automatic void queue_word(trsn_pkg::req_type w);
      pending_words.insert(pending_words.size(), w);
   endfunction

   // (2q-1)^2 * s <= 2^30 * r^2 decides whether q still rounds down to q or above
   function automatic bit rounds_up_to(longint unsigned q, longint unsigned s,
                                       longint unsigned r);
      logic [127:0] t, lhs, rhs;
      t = 128'(2 * q - 1);
      lhs = t * t * 128'(s);
      rhs = 128'(r);
      rhs = (rhs * rhs) << 30;
      return lhs <= rhs;
   endfunction

   // Q1.14 magnitude of r / sqrt(s), round to nearest, by bisection
   function automatic longint unsigned unit_component(longint unsigned r,
                                                      longint unsigned s);
      longint unsigned lo, hi, mid;
      lo = 0;
      hi = 16384;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         if (rounds_up_to(mid, s, r)) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   function automatic longint unsigned magnitude(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   // Radius test and face normal; returns 1 when the triangle is selected
   function automatic bit select_and_normal(input trsn_pkg::req_type w,
                                            input trsn_pkg::cfg_type c,
                                            output trsn_pkg::rsp_type o);
      longint dx, dz, e1x, e1y, e1z, e2x, e2y, e2z;
      longint cr[3];
      longint unsigned d2, lim, mx, s, q;
      longint unsigned m[3];
      logic signed [15:0] comp[3];
      o = '0;
      dx = longint'($signed(w.a_x)) + longint'($signed(w.b_x)) + longint'($signed(w.c_x))
           - 3 * longint'($signed(c.center_x));
      dz = longint'($signed(w.a_z)) + longint'($signed(w.b_z)) + longint'($signed(w.c_z))
           - 3 * longint'($signed(c.center_z));
      d2 = magnitude(dx) * magnitude(dx) + magnitude(dz) * magnitude(dz);
      lim = 9 * longint'(c.radius) * longint'(c.radius);
      if (d2 > lim) return 1'b0;
      e1x = longint'($signed(w.b_x)) - longint'($signed(w.a_x));
      e1y = longint'($signed(w.b_y)) - longint'($signed(w.a_y));
      e1z = longint'($signed(w.b_z)) - longint'($signed(w.a_z));
      e2x = longint'($signed(w.c_x)) - longint'($signed(w.a_x));
      e2y = longint'($signed(w.c_y)) - longint'($signed(w.a_y));
      e2z = longint'($signed(w.c_z)) - longint'($signed(w.a_z));
      cr[0] = e1y * e2z - e1z * e2y;
      cr[1] = e1z * e2x - e1x * e2z;
      cr[2] = e1x * e2y - e1y * e2x;
      o.tri_index = w.tri_index;
      o.placeable = w.placeable;
      mx = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = magnitude(cr[i]);
         if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) begin
         o.degenerate = 1'b1;
         return 1'b1;
      end
      // shrink until the largest magnitude fits 24 bits
      while (mx >= 64'd16777216) begin
         mx = mx >> 1;
         for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      end
      s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      for (int i = 0; i < 3; i++) begin
         q = unit_component(m[i], s);
         comp[i] = (cr[i] < 0) ? -16'(q) : 16'(q);
      end
      o.normal_x = comp[0];
      o.normal_y = comp[1];
      o.normal_z = comp[2];
      return 1'b1;
   endfunction

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int unsigned p;
      p = $urandom_range(99);
      if (p < 65) return 0;
      if (p < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   function automatic logic [23:0] near(logic signed [23:0] ctr, int unsigned spread);
      int off;
      off = int'($urandom_range(2 * spread)) - int'(spread);
      return 24'(int'(ctr) + off);
   endfunction

   // Triangle around a center point, or fully random with noise_pct odds
   function automatic trsn_pkg::req_type make_triangle(int unsigned spread,
                                                       int unsigned noise_pct);
      trsn_pkg::req_type w;
      w.tri_index = 16'($urandom);
      w.placeable = 1'($urandom);
      if ($urandom_range(99) < noise_pct) begin
         {w.a_x, w.a_y, w.a_z} = {24'($urandom), 24'($urandom), 24'($urandom)};
         {w.b_x, w.b_y, w.b_z} = {24'($urandom), 24'($urandom), 24'($urandom)};
         {w.c_x, w.c_y, w.c_z} = {24'($urandom), 24'($urandom), 24'($urandom)};
      end else begin
         w.a_x = near(shadow_cfg.center_x, spread);
         w.b_x = near(shadow_cfg.center_x, spread);
         w.c_x = near(shadow_cfg.center_x, spread);
         w.a_z = near(shadow_cfg.center_z, spread);
         w.b_z = near(shadow_cfg.center_z, spread);
         w.c_z = near(shadow_cfg.center_z, spread);
         w.a_y = 24'($urandom);
         w.b_y = near(w.a_y, spread);
         w.c_y = near(w.a_y, spread);
      end
      return w;
   endfunction

   function automatic trsn_pkg::req_type triangle(logic [15:0] idx, logic plc,
                                        int ax, int ay, int az, int bx, int by, int bz,
                                        int cx, int cy, int cz);
      trsn_pkg::req_type w;
      w.tri_index = idx;
      w.placeable = plc;
      w.a_x = 24'(ax); w.a_y = 24'(ay); w.a_z = 24'(az);
      w.b_x = 24'(bx); w.b_y = 24'(by); w.b_z = 24'(bz);
      w.c_x = 24'(cx); w.c_y = 24'(cy); w.c_z = 24'(cz);
      return w;
   endfunction

   // Driver: one word per handshake, random gaps between words
   always @(posedge clock) begin
      trsn_pkg::rsp_type hit;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
      end else begin
         if (req_valid && req_ready) begin
            if (select_and_normal(req_word, shadow_cfg, hit))
               expected_hits.insert(expected_hits.size(), hit);
         end
         if (req_valid && !req_ready) begin
            // hold the word until it is taken
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_words.size() > 0) begin
            req_word <= pending_words.pop_front();
            req_valid <= 1'b1;
            gap_left <= quiet ? 0 : pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Long receiver hold, counted here
   always @(posedge clock) begin
      if (hold_request) hold_left <= 300;
      else if (hold_left > 0) hold_left <= hold_left - 1;
   end

   // Monitor: compares each word taken with the oldest expected hit
   always @(posedge clock) begin
      trsn_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_hits.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected word: index %0d", rsp_tri_index_out);
            end else begin
               want = expected_hits.pop_front();
               if (rsp_tri_index_out !== want.tri_index || rsp_normal_x !== want.normal_x
                   || rsp_normal_y !== want.normal_y || rsp_normal_z !== want.normal_z
                   || rsp_placeable_out !== want.placeable
                   || rsp_degenerate !== want.degenerate) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp idx %0d n(%0d,%0d,%0d) p%0b d%0b, ",
                        want.tri_index, want.normal_x, want.normal_y, want.normal_z,
                        want.placeable, want.degenerate,
                        "got idx %0d n(%0d,%0d,%0d) p%0b d%0b",
                        rsp_tri_index_out, rsp_normal_x,
                        rsp_normal_y, rsp_normal_z, rsp_placeable_out, rsp_degenerate);
               end
            end
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            stall_left <= quiet ? 0 : pick_gap();
         end
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("[triangle_radius_select_normal_top] ERROR");
         $finish;
      end
   end

   task automatic write_reg(trsn_pkg::csr_index_type idx, logic [23:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      case (idx)
         trsn_pkg::CSR_CENTER_X: shadow_cfg.center_x = value;
         trsn_pkg::CSR_CENTER_Z: shadow_cfg.center_z = value;
         default: shadow_cfg.radius = value[22:0];
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic set_query(logic [23:0] cx, logic [23:0] cz, logic [23:0] r);
      write_reg(trsn_pkg::CSR_CENTER_X, cx);
      write_reg(trsn_pkg::CSR_CENTER_Z, cz);
      write_reg(trsn_pkg::CSR_RADIUS, r);
   endtask

   // Wait until all words are out, then let unselected ones clear the pipe
   task automatic drain();
      do @(posedge clock);
      while (pending_words.size() != 0 || req_valid || expected_hits.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int unsigned spread;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Zero radius after reset: only centroids exactly on the center pass
      queue_word(triangle(16'd0, 1'b0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      queue_word(triangle(16'd1, 1'b1, 0, 0, 0, 1, 5, 0, -1, 0, 0));
      queue_word(triangle(16'd2, 1'b1, 0, 0, 0, 3, 0, 1, -3, 7, -1));
      queue_word(triangle(16'd3, 1'b0, 1, 0, 0, 0, 0, 0, 0, 0, 0));
      queue_word(triangle(16'd4, 1'b1, 0, 0, 0, -1, 0, 1, 1, 0, -1));
      drain();

      // Extreme center and radius, extreme coordinates
      set_query(24'h800000, 24'h7FFFFF, 24'h7FFFFF);
      queue_word(triangle(16'hFFFF, 1'b1, -8388608, -8388608, 8388607,
         -8388608, 8388607, 8388607, 8388607, -8388608, -8388608));
      queue_word(triangle(16'h0000, 1'b0, -8388608, 8388607, 8388607,
         8388607, -8388608, 8388607, -8388608, -8388608, -8388608));
      queue_word(triangle(16'h8000, 1'b1, -8388608, 0, 8388607,
         -8388608, 0, 8388607, -8388608, 0, 8388607));
      queue_word(triangle(16'h7FFF, 1'b0, -8388608, 0, 8388607,
         -8388600, 0, 8388607, -8388608, 0, 8388600));
      queue_word(triangle(16'h1234, 1'b1, -8388608, 8388607, 8388607,
         -8388607, -8388608, 8388606, -8388606, 8388607, 8388605));
      queue_word(triangle(16'h5555, 1'b0, 8388607, 8388607, -8388608,
         8388607, -8388608, -8388608, -8388608, 8388607, 8388607));
      for (int i = 0; i < 8; i++) queue_word(make_triangle(64, 50));
      drain();

      // Center at origin, widest radius: mostly well-formed triangles
      set_query(24'h000000, 24'h000000, 24'h7FFFFF);
      for (int i = 0; i < 230; i++) begin
         spread = ($urandom_range(3) == 0) ? 24'h7FFFFF : $urandom_range(4096);
         queue_word(make_triangle(spread, 20));
      end
      drain();

      // Receiver holds off while the sender streams without gaps
      set_query(24'h000100, 24'hFFFF00, 24'h7FFFFF);
      quiet = 1'b1;
      for (int i = 0; i < 150; i++) queue_word(make_triangle(2048, 0));
      @(posedge clock);
      hold_request <= 1'b1;
      @(posedge clock);
      hold_request <= 1'b0;
      drain();
      quiet = 1'b0;

      // Random queries with triangles scaled to the radius
      for (int ph = 0; ph < 4; ph++) begin
         set_query(24'($urandom), 24'($urandom), 24'($urandom_range(24'h7FFFFF, 1)));
         for (int i = 0; i < 80; i++) begin
            spread = $urandom_range(int'(shadow_cfg.radius) + 16);
            queue_word(make_triangle(spread, 15));
         end
         drain();
      end

      // Small radius: near misses and exact hits
      set_query(24'h000010, 24'hFFFFF0, 24'h000001);
      for (int i = 0; i < 40; i++) queue_word(make_triangle(2, 5));
      drain();

      if (mismatches == 0) begin
         $display("[triangle_radius_select_normal_top] OK");
      end else begin
         $display("[triangle_radius_select_normal_top] ERROR");
      end
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/trsn_pkg.sv
hw/rtl/trsn_front.sv
hw/rtl/trsn_lane.sv
hw/rtl/trsn_outbuf.sv
hw/rtl/triangle_radius_select_normal_top.sv
test/tb_triangle_radius_select_normal_top.sv
